FILE: rtl/core/prm_pkg.sv
// ----------------------------------------------------------------------------
// prm_pkg
// Shared types and constants of the protocol reply matcher.
// ----------------------------------------------------------------------------
package prm_pkg;

  localparam int CMD_W = 3;
  localparam int OP_W  = 8;
  localparam int SEQ_W = 16;
  localparam int ASEQ_W = 32;
  localparam int CVAL_W = 32;
  localparam int CLS_W = 2;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 64;
  localparam int EVENT_SLOTS = 35;
  localparam int ERROR_SLOTS = 18;
  localparam int EV_CODE_MAX = 34;
  localparam int ERR_CODE_MAX = 17;
  localparam int REQ_BLK_MAX = 127;

  localparam logic [CMD_W-1:0] CMD_REQUEST = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REPLY   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ERROR   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_EVENT   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd5;

  localparam logic [CLS_W-1:0] CLS_REQ = 2'd0;
  localparam logic [CLS_W-1:0] CLS_EVT = 2'd1;
  localparam logic [CLS_W-1:0] CLS_ERR = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] REG_REQ_BLK_LO = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_REQ_BLK_HI = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_EVT_BLK    = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_CNT_EN     = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [OP_W-1:0]  opcode;
    logic [SEQ_W-1:0] reply_sequence;
    logic             from_server;
    logic             pre_ignored;
    logic [CLS_W-1:0] count_class;
  } prm_in_t;

  typedef struct packed {
    logic [ASEQ_W-1:0] assigned_sequence;
    logic [OP_W-1:0]   matched_request;
    logic              unexpected_reply;
    logic              blocked;
    logic              illegal_code;
    logic [CVAL_W-1:0] count_value;
    logic              table_full;
  } prm_out_t;

  // classified work item handed from the front to the back
  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [OP_W-1:0]   opcode;
    logic [SEQ_W-1:0]  seq;
    logic [ASEQ_W-1:0] assigned_sequence;
    logic              blocked;
    logic              push;
    logic              cnt_en;
    logic [CLS_W-1:0]  cls;
    logic              cnt_legal;
  } prm_work_t;

  function automatic logic expects_reply(input logic [OP_W-1:0] op);
    case (op)
      8'd3, 8'd14, 8'd15, 8'd16, 8'd17, 8'd20, 8'd21, 8'd23, 8'd26, 8'd31,
      8'd38, 8'd39, 8'd40, 8'd43, 8'd44, 8'd47, 8'd48, 8'd49, 8'd50, 8'd52,
      8'd73, 8'd83, 8'd84, 8'd85, 8'd86, 8'd87, 8'd91, 8'd92, 8'd97, 8'd98,
      8'd99, 8'd101, 8'd103, 8'd106, 8'd108, 8'd110, 8'd116, 8'd117, 8'd118,
      8'd119: expects_reply = 1'b1;
      default: expects_reply = 1'b0;
    endcase
  endfunction

endpackage

FILE: rtl/core/prm_if.sv
// ----------------------------------------------------------------------------
// prm_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface prm_stream_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/prm_front.sv
// ----------------------------------------------------------------------------
// prm_front
// Accepts items, applies blocking, advances the sequence counter and
// classifies the item for the back end.
// ----------------------------------------------------------------------------
module prm_front import prm_pkg::*; #(
  parameter int MAX_REQUEST_CODE = 255
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  prm_in_t         in_data,
  input  logic [63:0]     blk_lo,
  input  logic [63:0]     blk_hi,
  input  logic [34:0]     evt_blk,
  input  logic [2:0]      cnt_en,
  output logic            wq_valid,
  input  logic            wq_ready,
  output prm_work_t       wq_data
);

  logic [ASEQ_W-1:0] seq_r, seq_nxt;
  logic              blk;
  logic [6:0]        ev;
  logic              xfer;
  prm_work_t         w;

  assign in_ready = wq_ready;
  assign wq_valid = in_valid;
  assign xfer     = in_valid && wq_ready;
  assign ev       = in_data.opcode[6:0];

  always_comb begin
    blk = 1'b0;
    w = '0;
    w.command = in_data.command;
    w.opcode  = in_data.opcode;
    w.seq     = in_data.reply_sequence;
    w.cls     = in_data.count_class;
    case (in_data.command)
      CMD_REQUEST: begin
        blk = in_data.pre_ignored;
        if (in_data.opcode != '0 && !in_data.opcode[7] && in_data.opcode[6:0] < 7'd64 &&
            blk_lo[in_data.opcode[5:0]])
          blk = 1'b1;
        if (!in_data.opcode[7] && in_data.opcode[6] && blk_hi[in_data.opcode[5:0]])
          blk = 1'b1;
        w.cnt_en    = cnt_en[0];
        w.cnt_legal = (32'(in_data.opcode) <= 32'(MAX_REQUEST_CODE));
        w.push      = !blk && expects_reply(in_data.opcode);
        w.cls       = CLS_REQ;
      end
      CMD_ERROR: begin
        w.cnt_en    = cnt_en[2];
        w.cnt_legal = (in_data.opcode <= OP_W'(ERR_CODE_MAX));
        w.cls       = CLS_ERR;
      end
      CMD_EVENT: begin
        w.opcode = {1'b0, ev};
        if (in_data.from_server) begin
          w.cnt_en    = cnt_en[1];
          w.cnt_legal = (ev <= 7'(EV_CODE_MAX));
          if (ev >= 7'd2 && ev <= 7'(EV_CODE_MAX) && evt_blk[6'(ev)])
            blk = 1'b1;
        end
        w.cls = CLS_EVT;
      end
      default: ;
    endcase
    w.blocked = blk;
    seq_nxt = seq_r;
    if (in_data.command == CMD_REQUEST && !blk)
      seq_nxt = seq_r + 1'b1;
    w.assigned_sequence = seq_nxt;
  end

  assign wq_data = w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= '0;
    end else if (xfer) begin
      seq_r <= seq_nxt;
    end
  end

endmodule

FILE: rtl/core/prm_queue.sv
// ----------------------------------------------------------------------------
// prm_queue
// Two-entry queue decoupling the front end from the back end.
// ----------------------------------------------------------------------------
module prm_queue import prm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      s_valid,
  output logic      s_ready,
  input  prm_work_t s_data,
  output logic      m_valid,
  input  logic      m_ready,
  output prm_work_t m_data
);

  prm_work_t   mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        push, pop;

  assign s_ready = (cnt_r != 2'd2);
  assign m_valid = (cnt_r != 2'd0);
  assign m_data  = mem_r[rp_r];
  assign push    = s_valid && s_ready;
  assign pop     = m_valid && m_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= s_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: rtl/core/prm_back.sv
// ----------------------------------------------------------------------------
// prm_back
// Executes work items: pending table search/push, counter memories with
// read-modify-write, clears by sweep, and the registered result.
// ----------------------------------------------------------------------------
module prm_back import prm_pkg::*; #(
  parameter int PENDING_DEPTH    = 16,
  parameter int COUNT_WIDTH      = 32,
  parameter int MAX_REQUEST_CODE = 255
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      w_valid,
  output logic      w_ready,
  input  prm_work_t w_data,
  output logic      out_valid,
  input  logic      out_ready,
  output prm_out_t  out_data
);

  localparam int REQ_SLOTS = MAX_REQUEST_CODE + 1;
  localparam int PI_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int PC_W = $clog2(PENDING_DEPTH + 1);
  localparam int RA_W = $clog2(REQ_SLOTS);
  localparam int EA_W = $clog2(EVENT_SLOTS);
  localparam int KA_W = $clog2(ERROR_SLOTS);
  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SRCH  = 7'b0000010,
    S_SHIFT = 7'b0000100,
    S_RD    = 7'b0001000,
    S_WR    = 7'b0010000,
    S_SWEEP = 7'b0100000,
    S_INIT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [SEQ_W-1:0]   pe_seq_r [PENDING_DEPTH];
  logic [6:0]         pe_op_r  [PENDING_DEPTH];
  logic [PC_W-1:0]    pcnt_r;
  logic [PI_W-1:0]    idx_r;

  logic [COUNT_WIDTH-1:0] req_mem [REQ_SLOTS];
  logic [COUNT_WIDTH-1:0] evt_mem [EVENT_SLOTS];
  logic [COUNT_WIDTH-1:0] err_mem [ERROR_SLOTS];
  logic [COUNT_WIDTH-1:0] rd_r;
  logic [8:0]             swp_r;

  prm_work_t w_r;
  prm_out_t  res_r;
  prm_out_t  res_init;
  logic      ov_r;
  logic      bump;

  assign w_ready   = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_data  = res_r;
  assign bump      = w_r.cnt_en && w_r.cnt_legal;

  always_comb begin
    res_init = '0;
    res_init.assigned_sequence = w_data.assigned_sequence;
    res_init.blocked = w_data.blocked;
    res_init.illegal_code = w_data.cnt_en && !w_data.cnt_legal;
    res_init.unexpected_reply = (w_data.command == CMD_REPLY);
  end

  function automatic logic rd_ok(prm_work_t w);
    case (w.cls)
      CLS_REQ: rd_ok = 32'(w.opcode) < 32'(REQ_SLOTS);
      CLS_EVT: rd_ok = w.opcode < OP_W'(EVENT_SLOTS);
      CLS_ERR: rd_ok = w.opcode < OP_W'(ERROR_SLOTS);
      default: rd_ok = 1'b0;
    endcase
  endfunction

  logic [COUNT_WIDTH-1:0] inc;
  assign inc = (rd_r == CMAX) ? rd_r : rd_r + 1'b1;

  always_ff @(posedge clk) begin
    if (state_r == S_RD) begin
      case (w_r.cls)
        CLS_REQ: rd_r <= req_mem[w_r.opcode[RA_W-1:0]];
        CLS_EVT: rd_r <= evt_mem[w_r.opcode[EA_W-1:0]];
        default: rd_r <= err_mem[w_r.opcode[KA_W-1:0]];
      endcase
    end
  end

  // reset pass clears all classes together, one address per cycle
  always_ff @(posedge clk) begin
    if (state_r == S_INIT) begin
      req_mem[swp_r[RA_W-1:0]] <= '0;
      if (swp_r < 9'(EVENT_SLOTS)) evt_mem[swp_r[EA_W-1:0]] <= '0;
      if (swp_r < 9'(ERROR_SLOTS)) err_mem[swp_r[KA_W-1:0]] <= '0;
    end else if (state_r == S_SWEEP) begin
      case (w_r.cls)
        CLS_REQ: req_mem[swp_r[RA_W-1:0]] <= '0;
        CLS_EVT: evt_mem[swp_r[EA_W-1:0]] <= '0;
        default: err_mem[swp_r[KA_W-1:0]] <= '0;
      endcase
    end else if (state_r == S_WR && bump) begin
      case (w_r.cls)
        CLS_REQ: req_mem[w_r.opcode[RA_W-1:0]] <= inc;
        CLS_EVT: evt_mem[w_r.opcode[EA_W-1:0]] <= inc;
        default: err_mem[w_r.opcode[KA_W-1:0]] <= inc;
      endcase
    end
  end

  logic [8:0] swp_last;
  always_comb begin
    case (w_r.cls)
      CLS_REQ: swp_last = 9'(REQ_SLOTS - 1);
      CLS_EVT: swp_last = 9'(EVENT_SLOTS - 1);
      default: swp_last = 9'(ERROR_SLOTS - 1);
    endcase
  end

  logic hit, last_idx;
  assign hit      = (PC_W'(idx_r) < pcnt_r) && (pe_seq_r[idx_r] == w_r.seq);
  assign last_idx = (PC_W'(idx_r) + 1'b1 >= pcnt_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (w_valid && w_ready) begin
        case (w_data.command)
          CMD_REPLY, CMD_ERROR: state_nxt = S_SRCH;
          CMD_REQUEST, CMD_EVENT: state_nxt = (w_data.cnt_en && w_data.cnt_legal) ?
                                               S_RD : S_WR;
          CMD_CLEAR: state_nxt = (w_data.cls == 2'd3) ? S_WR : S_SWEEP;
          CMD_READ: state_nxt = S_RD;
          default: state_nxt = S_WR;
        endcase
      end
      S_SRCH: begin
        if (hit) state_nxt = S_SHIFT;
        else if (last_idx || pcnt_r == '0)
          state_nxt = (w_r.command == CMD_ERROR && bump) ? S_RD : S_WR;
      end
      S_SHIFT: if (last_idx)
        state_nxt = (w_r.command == CMD_ERROR && bump) ? S_RD : S_WR;
      S_RD: state_nxt = S_WR;
      S_WR: state_nxt = S_IDLE;
      S_SWEEP: if (swp_r == swp_last) state_nxt = S_WR;
      S_INIT: if (swp_r == 9'(REQ_SLOTS - 1)) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && w_valid && w_ready) w_r <= w_data;
    if (state_r == S_SHIFT && !last_idx) begin
      pe_seq_r[idx_r] <= pe_seq_r[PI_W'(idx_r + 1'b1)];
      pe_op_r[idx_r]  <= pe_op_r[PI_W'(idx_r + 1'b1)];
    end
    if (state_r == S_WR && w_r.push && pcnt_r != PC_W'(PENDING_DEPTH)) begin
      pe_seq_r[pcnt_r[PI_W-1:0]] <= w_r.assigned_sequence[SEQ_W-1:0];
      pe_op_r[pcnt_r[PI_W-1:0]]  <= w_r.opcode[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      pcnt_r  <= '0;
      idx_r   <= '0;
      swp_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ov_r && out_ready) ov_r <= 1'b0;
      case (state_r)
        S_INIT: swp_r <= swp_r + 1'b1;
        S_IDLE: begin
          idx_r <= '0;
          swp_r <= '0;
          if (w_valid && w_ready) res_r <= res_init;
        end
        S_SRCH: begin
          if (hit) begin
            res_r.matched_request <= {1'b0, pe_op_r[idx_r]};
            res_r.unexpected_reply <= 1'b0;
          end else if (!last_idx) begin
            idx_r <= PI_W'(idx_r + 1'b1);
          end
        end
        S_SHIFT: begin
          if (last_idx) pcnt_r <= pcnt_r - 1'b1;
          else idx_r <= PI_W'(idx_r + 1'b1);
        end
        S_SWEEP: swp_r <= swp_r + 1'b1;
        S_WR: begin
          ov_r <= 1'b1;
          if (w_r.push) begin
            if (pcnt_r == PC_W'(PENDING_DEPTH)) res_r.table_full <= 1'b1;
            else pcnt_r <= pcnt_r + 1'b1;
          end
          if (w_r.command == CMD_READ)
            res_r.count_value <= rd_ok(w_r) ? CVAL_W'(rd_r) : '0;
          else if (bump && w_r.command != CMD_CLEAR && w_r.command != CMD_REPLY)
            res_r.count_value <= CVAL_W'(inc);
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/protocol_reply_matcher.sv
// ----------------------------------------------------------------------------
// protocol_reply_matcher
// Request/reply protocol tracker with pending table and event counters.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one protocol item per transfer (request, reply, error, event,
//           clear counts, read count).
//   out_* : exactly one result per item, in order.
//   cfg_* : register writes (block masks, count enables), only when idle.
// Path (input transfer to out valid): the item passes the front, the queue
//   and the back end, which reads a counter in S_RD when it counts or reads
//   and registers the result in S_WR. Reply and error walk the pending
//   table one entry per cycle and compact it after a match; a counted error
//   then reads its counter. A clear sweeps the class's counter memory one
//   entry per cycle. Flow: one item at a time in the back end, which takes
//   the next only after its result is taken; a two-entry queue lets the
//   front accept while the back works.
// Reset: sequence counter zero, pending table empty, registers zero. The back
//   end then clears all counter memories, sweeping all classes together,
//   before it takes the first item.
// Stall: a held result keeps the back end waiting; the queue then fills and
//   in_ready drops.
// ----------------------------------------------------------------------------
module protocol_reply_matcher import prm_pkg::*; #(
  parameter int PENDING_DEPTH    = 16,
  parameter int COUNT_WIDTH      = 32,
  parameter int MAX_REQUEST_CODE = 255
) (
  input  logic                  clk,
  input  logic                  rst_n,
  prm_stream_if.sink            in_ch,
  prm_stream_if.source          out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [63:0] blk_lo_r, blk_hi_r;
  logic [34:0] evt_blk_r;
  logic [2:0]  cnt_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_lo_r  <= '0;
      blk_hi_r  <= '0;
      evt_blk_r <= '0;
      cnt_en_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REQ_BLK_LO: blk_lo_r  <= cfg_data;
        REG_REQ_BLK_HI: blk_hi_r  <= cfg_data;
        REG_EVT_BLK:    evt_blk_r <= cfg_data[34:0];
        REG_CNT_EN:     cnt_en_r  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  logic      fq_valid, fq_ready, qb_valid, qb_ready;
  prm_work_t fq_data, qb_data;

  prm_front #(.MAX_REQUEST_CODE(MAX_REQUEST_CODE)) u_front (
    .clk, .rst_n,
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_data  (in_ch.data),
    .blk_lo   (blk_lo_r),
    .blk_hi   (blk_hi_r),
    .evt_blk  (evt_blk_r),
    .cnt_en   (cnt_en_r),
    .wq_valid (fq_valid),
    .wq_ready (fq_ready),
    .wq_data  (fq_data)
  );

  prm_queue u_queue (
    .clk, .rst_n,
    .s_valid (fq_valid), .s_ready (fq_ready), .s_data (fq_data),
    .m_valid (qb_valid), .m_ready (qb_ready), .m_data (qb_data)
  );

  prm_back #(
    .PENDING_DEPTH(PENDING_DEPTH), .COUNT_WIDTH(COUNT_WIDTH),
    .MAX_REQUEST_CODE(MAX_REQUEST_CODE)
  ) u_back (
    .clk, .rst_n,
    .w_valid   (qb_valid), .w_ready (qb_ready), .w_data (qb_data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
  );

endmodule

FILE: rtl/core/prm_checker.sv
// ----------------------------------------------------------------------------
// prm_checker
// Port-level checks of the protocol reply matcher.
// ----------------------------------------------------------------------------
module prm_checker import prm_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_ready,
  input prm_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_unexp_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.unexpected_reply |-> out_data.matched_request == '0)
    else $error("unexpected reply with match");

  a_match_7bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_data.matched_request[7])
    else $error("matched opcode wider than 7 bits");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind protocol_reply_matcher prm_checker u_prm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
